[sv/sct_pkg.sv]
package sct_pkg;

    localparam int MAX_SECTIONS       = 256;
    localparam int MIN_SECTION_LENGTH = 12;

    localparam int INDEX_W = $clog2(MAX_SECTIONS);
    localparam int COUNT_W = INDEX_W + 1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_BADNUM = 3'd2;
    localparam logic [2:0] ST_VERCHG = 3'd3;
    localparam logic [2:0] ST_CRC    = 3'd4;
    localparam logic [2:0] ST_PARAM  = 3'd5;

    typedef struct packed {
        logic        payload_present;
        logic [12:0] pid;
        logic [12:0] section_length;
        logic [31:0] crc_field;
        logic [31:0] crc_computed;
        logic [7:0]  section_index;
        logic [7:0]  last_index;
        logic [4:0]  table_version;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       complete;
        logic [4:0] changed_version;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } cmd_t;

endpackage

[sv/sct_controller.sv]
module sct_controller
    import sct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic clear_last,
    output logic busy,
    output cmd_t cmd,
    output logic result_valid
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next        = S_IDLE;
                result_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.load     = start && (state_reg == S_IDLE);
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.clear    = (state_reg == S_CLEAR);
    assign result_valid = result_valid_reg;

endmodule

[sv/sct_datapath.sv]
module sct_datapath
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  item_t       item,
    input  logic        wr_en,
    input  logic [12:0] wr_data,
    output logic        clear_last,
    output result_t     result
);

    item_t                item_reg;
    result_t              result_reg;
    result_t              result_next;
    logic [12:0]          filter_pid_reg;
    logic                 started_reg;
    logic                 started_next;
    logic                 flag_mem [MAX_SECTIONS];
    logic                 flag_rd_reg;
    logic [INDEX_W-1:0]   clr_addr_reg;
    logic [COUNT_W-1:0]   expected_count_reg;
    logic [COUNT_W-1:0]   expected_count_next;
    logic [COUNT_W-1:0]   received_count_reg;
    logic [COUNT_W-1:0]   received_count_next;
    logic [4:0]           held_version_reg;
    logic [4:0]           held_version_next;
    logic [4:0]           new_version_reg;
    logic [4:0]           new_version_next;
    logic                 done_reg;
    logic                 done_next;

    logic                 param_err;
    logic                 crc_err;
    logic [COUNT_W-1:0]   first_count;
    logic [COUNT_W-1:0]   eff_expected;
    logic [COUNT_W-1:0]   eff_received;
    logic [COUNT_W-1:0]   count_inc;
    logic [INDEX_W-1:0]   sec;
    logic                 bad_num;
    logic                 flag_set;
    logic                 flag_we;
    logic [INDEX_W-1:0]   flag_addr;
    logic                 flag_wdata;

    assign sec       = item_reg.section_index[INDEX_W-1:0];
    assign param_err = !item_reg.payload_present
                    || (item_reg.section_length < 13'(MIN_SECTION_LENGTH))
                    || (item_reg.pid != filter_pid_reg);
    assign crc_err   = (item_reg.crc_field != item_reg.crc_computed);

    // last_index + 1 saturated at the flag store depth
    always_comb
    begin
        first_count = {1'b0, item_reg.last_index} + COUNT_W'(1);
        if (first_count > COUNT_W'(MAX_SECTIONS))
        begin
            first_count = COUNT_W'(MAX_SECTIONS);
        end
    end

    // first good section behaves as if the tracker state were fresh;
    // the flag store is all zero until then, so its read needs no masking
    assign eff_expected = started_reg ? expected_count_reg : first_count;
    assign eff_received = started_reg ? received_count_reg : '0;
    assign bad_num      = ({1'b0, sec} >= eff_expected);
    assign count_inc    = eff_received + COUNT_W'(1);

    always_comb
    begin
        started_next        = started_reg;
        expected_count_next = expected_count_reg;
        received_count_next = received_count_reg;
        held_version_next   = held_version_reg;
        new_version_next    = new_version_reg;
        done_next           = done_reg;
        flag_set            = 1'b0;
        result_next.status  = ST_OK;

        if (param_err)
        begin
            result_next.status = ST_PARAM;
        end
        else if (crc_err)
        begin
            result_next.status = ST_CRC;
        end
        else if (done_reg)
        begin
            if (item_reg.table_version != held_version_reg)
            begin
                new_version_next   = item_reg.table_version;
                result_next.status = ST_VERCHG;
            end
            else
            begin
                result_next.status = ST_DUP;
            end
        end
        else
        begin
            if (!started_reg)
            begin
                started_next        = 1'b1;
                expected_count_next = first_count;
                received_count_next = '0;
                held_version_next   = item_reg.table_version;
            end
            if (bad_num)
            begin
                result_next.status = ST_BADNUM;
            end
            else if (flag_rd_reg)
            begin
                result_next.status = ST_DUP;
            end
            else
            begin
                flag_set            = 1'b1;
                received_count_next = count_inc;
                if (count_inc >= eff_expected)
                begin
                    done_next = 1'b1;
                end
            end
        end

        result_next.complete        = done_next;
        result_next.changed_version = new_version_next;
    end

    // flag store port: clearing pass after reset, then single-bit sets
    always_comb
    begin
        flag_we    = cmd.exec && flag_set;
        flag_addr  = sec;
        flag_wdata = 1'b1;
        if (cmd.clear)
        begin
            flag_we    = 1'b1;
            flag_addr  = clr_addr_reg;
            flag_wdata = 1'b0;
        end
    end

    assign clear_last = (clr_addr_reg == INDEX_W'(MAX_SECTIONS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg    <= item;
            flag_rd_reg <= flag_mem[item.section_index[INDEX_W-1:0]];
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
        if (flag_we)
        begin
            flag_mem[flag_addr] <= flag_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_pid_reg     <= '0;
            started_reg        <= 1'b0;
            clr_addr_reg       <= '0;
            expected_count_reg <= '0;
            received_count_reg <= '0;
            held_version_reg   <= '0;
            new_version_reg    <= 5'd31;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filter_pid_reg <= wr_data;
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + INDEX_W'(1);
            end
            if (cmd.exec)
            begin
                started_reg        <= started_next;
                expected_count_reg <= expected_count_next;
                received_count_reg <= received_count_next;
                held_version_reg   <= held_version_next;
                new_version_reg    <= new_version_next;
                done_reg           <= done_next;
            end
        end
    end

    assign result = result_reg;

    // the running count stands in for a scan of the flags
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        received_count_reg <= expected_count_reg)
        else $error("received count above expected count");

    a_done_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> started_reg)
        else $error("table complete before any section was taken");

    a_version_change_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (new_version_reg != $past(new_version_reg)) |-> $past(done_reg))
        else $error("new version recorded before table was complete");

endmodule

[sv/section_collection_tracker_core.sv]
// result_valid and result are registered at the end of the S_EXEC state that follows the taken start
// start is not taken again until the tracker is back in S_IDLE (flag read at the load edge, then
//   the S_EXEC state for the count compare and state update)
// the receiver cannot stall; result_valid lasts exactly one cycle, result holds until the next update
// reset: asynchronous, active low; clears tracker state and filter pid, then busy stays
//   high while all 256 flag store entries are cleared
module section_collection_tracker_core
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    input  logic        wr_en,
    input  logic [12:0] wr_data,
    output logic        result_valid,
    output result_t     result
);

    cmd_t cmd;
    logic clear_last;

    sct_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .clear_last   (clear_last),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid)
    );

    sct_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .clear_last (clear_last),
        .result     (result)
    );

endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       hdr = '0;
    logic        wr_en = 1'b0;
    logic [12:0] wr_data = '0;
    logic        result_valid;
    result_t     outcome;

    section_collection_tracker_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (hdr),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .result       (outcome)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // tracker copy, starts at its reset values
    logic [12:0]             model_pid = '0;
    logic                    trk_started = 1'b0;
    logic [MAX_SECTIONS-1:0] trk_flags = '0;
    logic [COUNT_W-1:0]      trk_expected = '0;
    logic [COUNT_W-1:0]      trk_received = '0;
    logic [4:0]              trk_held_ver = '0;
    logic [4:0]              trk_new_ver = 5'd31;
    logic                    trk_done = 1'b0;

    item_t   pending_sections[$];
    result_t expected_outcomes[$];
    int      gap_pct = 0;
    int      mismatches = 0;
    int      sections_sent = 0;
    int      outcomes_checked = 0;
    int      stall_cycles = 0;
    int      status_tally[8];

    // generator's view of the table
    int         open_sections[$];
    logic [7:0] table_last;
    logic [4:0] table_version;

    function automatic result_t track_section(input item_t s);
        result_t            r;
        logic [2:0]         st;
        logic [COUNT_W-1:0] cnt;
        if (!s.payload_present || s.section_length < MIN_SECTION_LENGTH
            || s.pid != model_pid)
            st = ST_PARAM;
        else if (s.crc_field != s.crc_computed)
            st = ST_CRC;
        else if (trk_done)
        begin
            if (s.table_version != trk_held_ver)
            begin
                trk_new_ver = s.table_version;
                st = ST_VERCHG;
            end
            else
                st = ST_DUP;
        end
        else
        begin
            // first good section fixes the table shape
            if (!trk_started)
            begin
                cnt = {1'b0, s.last_index} + 1'b1;
                if (cnt > MAX_SECTIONS)
                    cnt = COUNT_W'(MAX_SECTIONS);
                trk_expected = cnt;
                trk_received = '0;
                trk_flags = '0;
                trk_held_ver = s.table_version;
                trk_started = 1'b1;
            end
            if ({1'b0, s.section_index} >= trk_expected)
                st = ST_BADNUM;
            else if (trk_flags[s.section_index])
                st = ST_DUP;
            else
            begin
                trk_flags[s.section_index] = 1'b1;
                trk_received = trk_received + 1'b1;
                if (trk_received >= trk_expected)
                    trk_done = 1'b1;
                st = ST_OK;
            end
        end
        r.status = st;
        r.complete = trk_done;
        r.changed_version = trk_new_ver;
        return r;
    endfunction

    // driver: hold start until taken, random gaps between transactions
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_outcomes.push_back(track_section(hdr));
            sections_sent++;
        end
        if (!start || !busy)
        begin
            if (pending_sections.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                start <= 1'b1;
                hdr <= pending_sections.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else if (result_valid)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result: status %0d complete %0d changed_version %0d",
                           outcome.status, outcome.complete, outcome.changed_version);
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    outcomes_checked++;
                    status_tally[want.status]++;
                    if (outcome.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, outcome.status);
                        mismatches++;
                    end
                    if (outcome.complete !== want.complete)
                    begin
                        $error("complete: expected %0d, got %0d",
                               want.complete, outcome.complete);
                        mismatches++;
                    end
                    if (outcome.changed_version !== want.changed_version)
                    begin
                        $error("changed_version: expected %0d, got %0d",
                               want.changed_version, outcome.changed_version);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic item_t make_section(input logic [7:0] sec, input logic [7:0] last,
                                           input logic [4:0] ver);
        item_t s;
        s.payload_present = 1'b1;
        s.pid = model_pid;
        if ($urandom_range(3) == 0)
            s.section_length = 13'($urandom_range(8191, MIN_SECTION_LENGTH));
        else
            s.section_length = 13'($urandom_range(4096, MIN_SECTION_LENGTH));
        s.crc_field = $urandom;
        s.crc_computed = s.crc_field;
        s.section_index = sec;
        s.last_index = last;
        s.table_version = ver;
        return s;
    endfunction

    function automatic item_t make_broken();
        item_t       s;
        logic [31:0] flip;
        int          pick;
        s = make_section(8'($urandom), 8'($urandom), 5'($urandom));
        flip = $urandom;
        if (flip == 0)
            flip = 32'd1;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            s.payload_present = 1'b0;
            s.pid = 13'($urandom);
            s.section_length = 13'($urandom);
            if (pick < 10)
                s.crc_computed = s.crc_field ^ flip;
        end
        else if (pick < 50)
            s.section_length = 13'($urandom_range(MIN_SECTION_LENGTH - 1, 0));
        else if (pick < 75)
            s.pid = model_pid ^ 13'($urandom_range(8191, 1));
        else
            s.crc_computed = s.crc_field ^ flip;
        return s;
    endfunction

    task automatic queue_random_sections(input int n);
        item_t s;
        int    k;
        int    pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                s = make_broken();
            else if (open_sections.size() != 0)
            begin
                // still collecting: mostly missing sections, some repeats and strays
                if (pick < 70)
                begin
                    k = $urandom_range(open_sections.size() - 1);
                    s = make_section(8'(open_sections[k]), 8'($urandom), 5'($urandom));
                    open_sections.delete(k);
                end
                else if (pick < 85)
                    s = make_section(8'($urandom_range(table_last)), 8'($urandom),
                                     5'($urandom));
                else
                    s = make_section(8'($urandom_range(255)), 8'($urandom), 5'($urandom));
            end
            else if (pick < 55)
                s = make_section(8'($urandom), 8'($urandom), table_version);
            else
                s = make_section(8'($urandom), 8'($urandom), 5'($urandom));
            pending_sections.push_back(s);
        end
    endtask

    task automatic wait_drained();
        while (pending_sections.size() != 0 || start || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic program_filter(input logic [12:0] v);
        wait_drained();
        @(posedge clk);
        wr_en <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        model_pid = v;
    endtask

    initial
    begin : stimulus
        item_t       s;
        logic [12:0] pid_b;
        logic [12:0] pid_c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 36;
        program_filter(13'h1FFF);
        table_last = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(254, 40));
        table_version = 5'($urandom);

        // parameter errors, including one that also has a bad crc
        s = make_section(8'd0, table_last, table_version);
        s.payload_present = 1'b0;
        pending_sections.push_back(s);
        s = make_section(8'd0, table_last, table_version);
        s.section_length = 13'(MIN_SECTION_LENGTH - 1);
        pending_sections.push_back(s);
        s = make_section(8'd0, table_last, table_version);
        s.section_length = '0;
        pending_sections.push_back(s);
        s = make_section(8'd0, table_last, table_version);
        s.pid = '0;
        pending_sections.push_back(s);
        s = make_section(8'd0, table_last, table_version);
        s.payload_present = 1'b0;
        s.crc_computed = ~s.crc_field;
        pending_sections.push_back(s);
        // crc errors at both length extremes
        s = make_section(8'd0, table_last, table_version);
        s.section_length = 13'(MIN_SECTION_LENGTH);
        s.crc_computed = s.crc_field ^ 32'h0000_0001;
        pending_sections.push_back(s);
        s = make_section(8'd0, table_last, table_version);
        s.section_length = 13'h1FFF;
        s.crc_field = '0;
        s.crc_computed = '1;
        pending_sections.push_back(s);
        // first good section is out of range unless table_last is 255, yet still fixes count and version
        s = make_section(8'd255, table_last, table_version);
        s.section_length = 13'(MIN_SECTION_LENGTH);
        s.crc_field = '1;
        s.crc_computed = '1;
        pending_sections.push_back(s);
        s = make_section(8'd0, 8'($urandom), table_version);
        s.crc_field = '0;
        s.crc_computed = '0;
        pending_sections.push_back(s);
        pending_sections.push_back(make_section(8'd0, 8'($urandom), table_version));
        s = make_section(table_last, 8'($urandom), table_version);
        s.section_length = 13'h1FFF;
        pending_sections.push_back(s);
        pending_sections.push_back(make_section(8'(table_last + 1), 8'd0, table_version));
        // version is ignored until the table is complete
        pending_sections.push_back(make_section(8'd0, 8'd255, ~table_version));

        for (int i = 1; i < table_last; i++)
            open_sections.push_back(i);

        program_filter(13'd0);
        queue_random_sections(560);

        pid_b = 13'($urandom_range(8190, 1));
        program_filter(pid_b);
        gap_pct = 82;
        queue_random_sections(560);

        pid_c = 13'($urandom);
        program_filter(pid_c);
        gap_pct = 0;
        queue_random_sections(570);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d sections over filter pids 8191, 0, %0d, %0d; %0d results",
                 sections_sent, pid_b, pid_c, outcomes_checked);
        $display("ok %0d dup %0d bad number %0d version change %0d crc %0d param %0d",
                 status_tally[ST_OK], status_tally[ST_DUP], status_tally[ST_BADNUM],
                 status_tally[ST_VERCHG], status_tally[ST_CRC], status_tally[ST_PARAM]);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[section_collection_tracker_core.f]
sv/sct_pkg.sv
sv/sct_controller.sv
sv/sct_datapath.sv
sv/section_collection_tracker_core.sv
bench/tb_top.sv
